@@ hw/rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// opcodes, status codes, transaction payloads, controller state and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int TIME_BITS_DEF = 32;
	localparam int NUM_IDS       = 32;
	localparam int ID_W          = 5;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_ADJUST = 2'd1,
		FN_DELETE = 2'd2,
		FN_TICK   = 2'd3
	} stq_func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_DUP     = 2'd2,
		ST_FULL    = 2'd3
	} stq_status_t;

	typedef enum logic {
		KIND_STATUS  = 1'b0,
		KIND_EXPIRED = 1'b1
	} stq_kind_t;

	typedef struct packed {
		logic [1:0]      func;
		logic [ID_W-1:0] timer_id;
		logic [31:0]     expire_time;
		logic [31:0]     now_time;
	} stq_req_t;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] expired_id;
		logic [1:0]      status;
		logic            any_expired;
		logic            last;
	} stq_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_PROC
	} stq_state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic rd;
		logic step;
	} stq_cmd_t;

	typedef struct packed {
		logic err;
		logic emit_ok;
		logic step_emit;
		logic at_end;
	} stq_sts_t;

endpackage

@@ hw/rtl/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// stq_ctrl: sequencer of the sorted timer queue
// walks check, read and process steps over the sorted list
// ----------------------------------------------------------------------------
module stq_ctrl
	import stq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  stq_sts_t sts,
	output stq_cmd_t cmd
);

	stq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.err) state_d = S_READ;
				else if (sts.emit_ok) state_d = S_IDLE;
			end
			S_READ: begin
				state_d = S_PROC;
			end
			S_PROC: begin
				if (!sts.step_emit || sts.emit_ok) begin
					state_d = sts.at_end ? S_IDLE : S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			S_CHECK: cmd.check = !sts.err || sts.emit_ok;
			S_READ:  cmd.rd    = 1'b1;
			S_PROC:  cmd.step  = !sts.step_emit || sts.emit_ok;
			default: cmd       = '0;
		endcase
	end

endmodule

@@ hw/rtl/stq_dp.sv @@
// ----------------------------------------------------------------------------
// stq_dp: datapath of the sorted timer queue
// list memory of id and expiry, in-place compaction with a one-entry carry
// ----------------------------------------------------------------------------
module stq_dp
	import stq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  stq_req_t req,
	input  stq_cmd_t cmd,
	output stq_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output stq_rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// list memory
	logic [ID_W-1:0]      id_mem [DEPTH];
	logic [TIME_BITS-1:0] tm_mem [DEPTH];

	stq_func_t            op_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] exp_q, now_q;
	logic [CW-1:0]        r_q, w_q, count_q;
	logic                 carry_v_q, ins_done_q, expiring_q, pend_v_q;
	logic [ID_W-1:0]      carry_id_q, pend_id_q, rd_id_q;
	logic [TIME_BITS-1:0] carry_t_q, rd_t_q;
	logic [NUM_IDS-1:0]   active_q;
	logic                 out_v_q;
	stq_rsp_t             out_q;

	logic                 at_end, drop, ins, keep, ins_op, expired_now;
	logic                 have_1st, have_2nd, we, emit_fire, step_emit;
	logic [ID_W-1:0]      id_1st, id_2nd;
	logic [TIME_BITS-1:0] t_1st, t_2nd;
	stq_status_t          err_code;
	stq_rsp_t             emit_d;

	assign at_end = (r_q == count_q);
	assign ins_op = (op_q == FN_ADD) || (op_q == FN_ADJUST);

	always_comb begin
		err_code = ST_OK;
		case (op_q)
			FN_ADD: begin
				if (active_q[id_q]) err_code = ST_DUP;
				else if (count_q >= CW'(DEPTH)) err_code = ST_FULL;
			end
			FN_ADJUST, FN_DELETE: begin
				if (!active_q[id_q]) err_code = ST_UNKNOWN;
			end
			default: err_code = ST_OK;
		endcase
	end

	// per-entry decision
	always_comb begin
		drop = 1'b0;
		if (!at_end) begin
			if ((op_q == FN_ADJUST || op_q == FN_DELETE) && rd_id_q == id_q) drop = 1'b1;
			if (op_q == FN_TICK && expiring_q && rd_t_q <= now_q) drop = 1'b1;
		end
		keep        = !at_end && !drop;
		ins         = ins_op && !ins_done_q && (at_end || (keep && rd_t_q > exp_q));
		expired_now = (op_q == FN_TICK) && drop;

		// output stream of this step: carry or new, then the read entry
		have_1st = 1'b0; have_2nd = 1'b0;
		id_1st = rd_id_q; t_1st = rd_t_q;
		id_2nd = rd_id_q; t_2nd = rd_t_q;
		if (carry_v_q) begin
			have_1st = 1'b1; id_1st = carry_id_q; t_1st = carry_t_q;
			if (keep) begin
				have_2nd = 1'b1;
			end else if (ins) begin
				have_2nd = 1'b1; id_2nd = id_q; t_2nd = exp_q;
			end
		end else if (ins) begin
			have_1st = 1'b1; id_1st = id_q; t_1st = exp_q;
			have_2nd = keep;
		end else if (keep) begin
			have_1st = 1'b1;
		end
	end

	assign we = cmd.step && have_1st;

	always_comb begin
		emit_d = '0;
		emit_d.last = 1'b1;
		step_emit = 1'b0;
		if (op_q == FN_TICK) begin
			if (expired_now && pend_v_q) begin
				step_emit          = 1'b1;
				emit_d.kind        = KIND_EXPIRED;
				emit_d.expired_id  = pend_id_q;
				emit_d.any_expired = 1'b1;
				emit_d.last        = 1'b0;
			end else if (at_end) begin
				step_emit          = 1'b1;
				emit_d.kind        = pend_v_q ? KIND_EXPIRED : KIND_STATUS;
				emit_d.expired_id  = pend_v_q ? pend_id_q : '0;
				emit_d.any_expired = pend_v_q;
			end
		end else begin
			step_emit = at_end;
		end
		if (cmd.check) emit_d.status = err_code;
	end

	assign sts.step_emit = step_emit;
	assign sts.err       = (err_code != ST_OK);
	assign sts.emit_ok   = !out_v_q || !rsp_stall;
	assign sts.at_end    = at_end;
	assign emit_fire     = (cmd.check && sts.err) || (cmd.step && step_emit);

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.rd && !at_end) begin
			rd_id_q <= id_mem[r_q[AW-1:0]];
			rd_t_q  <= tm_mem[r_q[AW-1:0]];
		end
		if (we) begin
			id_mem[w_q[AW-1:0]] <= id_1st;
			tm_mem[w_q[AW-1:0]] <= t_1st;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= stq_func_t'(req.func);
			id_q  <= req.timer_id;
			exp_q <= TIME_BITS'(req.expire_time);
			now_q <= TIME_BITS'(req.now_time);
		end
		if (cmd.step) begin
			carry_id_q <= id_2nd;
			carry_t_q  <= t_2nd;
			if (expired_now) pend_id_q <= rd_id_q;
		end
		if (emit_fire) out_q <= emit_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q        <= '0;
			w_q        <= '0;
			count_q    <= '0;
			carry_v_q  <= 1'b0;
			ins_done_q <= 1'b0;
			expiring_q <= 1'b0;
			pend_v_q   <= 1'b0;
			active_q   <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.check && !sts.err) begin
				r_q        <= '0;
				w_q        <= '0;
				carry_v_q  <= 1'b0;
				ins_done_q <= 1'b0;
				expiring_q <= 1'b1;
				pend_v_q   <= 1'b0;
				if (op_q == FN_ADD) active_q[id_q] <= 1'b1;
				if (op_q == FN_DELETE) active_q[id_q] <= 1'b0;
			end
			if (cmd.step) begin
				carry_v_q <= have_2nd;
				if (ins) ins_done_q <= 1'b1;
				if (we) w_q <= w_q + CW'(1);
				if (!at_end) r_q <= r_q + CW'(1);
				if (op_q == FN_TICK && keep) expiring_q <= 1'b0;
				if (expired_now) begin
					pend_v_q           <= 1'b1;
					active_q[rd_id_q]  <= 1'b0;
				end
				if (at_end) count_q <= w_q + CW'(we);
			end
			if (emit_fire) out_v_q <= 1'b1;
			else if (!rsp_stall) out_v_q <= 1'b0;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");
	a_write_behind: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, w_q} <= {1'b0, r_q} + (CW+1)'(1))
		else $error("write pointer overtook read pointer");
	a_carry_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && at_end |=> !carry_v_q)
		else $error("carry left full after last step");
	a_active_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> ($countones(active_q) == int'(count_q)))
		else $error("active flags disagree with list length");
`endif

endmodule

@@ hw/rtl/sorted_timer_queue_top.sv @@
// result: a rejected request gets a single status transaction from the check
//   step, otherwise the list is walked with a read and a process step per entry
// throughput: one request at a time, req_stall stays high until the list walk ends
// reset: arst_n clears the list length, active flags and output valid
// ----------------------------------------------------------------------------
// sorted_timer_queue_top: timer list kept in ascending expiry order
// add, adjust, delete and tick over a list memory walked one entry at a time
// ----------------------------------------------------------------------------
module sorted_timer_queue_top
	import stq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	// request channel
	input  logic     req_valid,
	output logic     req_stall,
	input  stq_req_t req,
	// result channel, one or more transactions per request
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output stq_rsp_t rsp
);

	// command and status between sequencer and datapath
	stq_cmd_t cmd;
	stq_sts_t sts;

	// sequencer: check, then read and process each list entry
	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: list memory, compaction carry, output register
	stq_dp #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ tb/sorted_timer_queue_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top_test: self-checking bench for the sorted timer queue
// requests go in through the valid/stall channel, a behavioural copy of the
// timer list predicts every result transaction, and each transaction that
// leaves the block is compared field by field in arrival order
// ----------------------------------------------------------------------------
module sorted_timer_queue_top_test;
	import stq_pkg::*;

	localparam int DEPTH     = DEPTH_DEF;
	localparam int MAX_CYC   = 400000;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	stq_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	stq_rsp_t rsp;

	sorted_timer_queue_top #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS_DEF)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// predicted timer list state
	logic [ID_W-1:0] list_ids[DEPTH];
	logic [31:0]     expiry_of[NUM_IDS];
	logic            active_of[NUM_IDS];
	int              list_len;

	stq_rsp_t pending_rsp[$];
	int       n_err;
	int       n_cyc;
	bit       quiet;   // no idling on either side in the last part

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		n_cyc <= n_cyc + 1;
		if (n_cyc > MAX_CYC) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// drop an id from the ordered list
	function automatic void list_drop(input logic [ID_W-1:0] id);
		int i;
		int j;
		for (i = 0; i < list_len; i++) begin
			if (list_ids[i] == id) begin
				for (j = i; j + 1 < list_len; j++)
					list_ids[j] = list_ids[j + 1];
				list_len--;
				return;
			end
		end
	endfunction

	// place an id after every entry with an expiry not later than its own
	function automatic void list_place(input logic [ID_W-1:0] id);
		int pos;
		int j;
		pos = 0;
		if (list_len >= DEPTH)
			return;
		while (pos < list_len && expiry_of[list_ids[pos]] <= expiry_of[id])
			pos++;
		for (j = list_len; j > pos; j--)
			list_ids[j] = list_ids[j - 1];
		list_ids[pos] = id;
		list_len++;
	endfunction

	function automatic stq_rsp_t status_rsp(input stq_status_t st);
		stq_rsp_t r;
		r = '0;
		r.kind   = KIND_STATUS;
		r.status = st;
		r.last   = 1'b1;
		return r;
	endfunction

	// work out the result transactions of one accepted request
	function automatic void predict_timers(input stq_req_t q);
		stq_rsp_t r;
		int n;
		int k;
		case (stq_func_t'(q.func))
			FN_ADD: begin
				if (active_of[q.timer_id])
					pending_rsp.push_back(status_rsp(ST_DUP));
				else if (list_len >= DEPTH)
					pending_rsp.push_back(status_rsp(ST_FULL));
				else begin
					expiry_of[q.timer_id] = q.expire_time;
					active_of[q.timer_id] = 1'b1;
					list_place(q.timer_id);
					pending_rsp.push_back(status_rsp(ST_OK));
				end
			end
			FN_ADJUST: begin
				if (!active_of[q.timer_id])
					pending_rsp.push_back(status_rsp(ST_UNKNOWN));
				else begin
					list_drop(q.timer_id);
					expiry_of[q.timer_id] = q.expire_time;
					list_place(q.timer_id);
					pending_rsp.push_back(status_rsp(ST_OK));
				end
			end
			FN_DELETE: begin
				if (!active_of[q.timer_id])
					pending_rsp.push_back(status_rsp(ST_UNKNOWN));
				else begin
					list_drop(q.timer_id);
					active_of[q.timer_id] = 1'b0;
					pending_rsp.push_back(status_rsp(ST_OK));
				end
			end
			default: begin
				n = 0;
				while (n < list_len && expiry_of[list_ids[n]] <= q.now_time)
					n++;
				if (n == 0)
					pending_rsp.push_back(status_rsp(ST_OK));
				for (k = 0; k < n; k++) begin
					r = '0;
					r.kind        = KIND_EXPIRED;
					r.expired_id  = list_ids[k];
					r.any_expired = 1'b1;
					r.last        = (k + 1 == n);
					active_of[list_ids[k]] = 1'b0;
					pending_rsp.push_back(r);
				end
				for (k = n; k < list_len; k++)
					list_ids[k - n] = list_ids[k];
				list_len -= n;
			end
		endcase
	endfunction

	// result side: random stall bursts, compare each accepted transaction
	initial begin
		int burst;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected transaction %h", rsp);
				end else begin
					stq_rsp_t want;
					want = pending_rsp.pop_front();
					if (rsp !== want) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch: want kind %0d id %0d st %0d any %0d last %0d, got kind %0d id %0d st %0d any %0d last %0d",
								want.kind, want.expired_id, want.status, want.any_expired, want.last,
								rsp.kind, rsp.expired_id, rsp.status, rsp.any_expired, rsp.last);
					end
				end
			end
			if (burst > 0) begin
				burst--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 5);
				rsp_stall <= 1'b1;
			end else
				rsp_stall <= 1'b0;
		end
	end

	// send one request; optional random idle burst first
	task automatic send_req(input stq_func_t f, input logic [ID_W-1:0] id,
			input logic [31:0] et, input logic [31:0] nt);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		req.func      <= f;
		req.timer_id  <= id;
		req.expire_time <= et;
		req.now_time  <= nt;
		do @(posedge clk); while (req_stall);
		predict_timers('{func: f, timer_id: id, expire_time: et, now_time: nt});
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);
	endtask

	// field extremes, every operation and the named special cases
	task automatic test_directed();
		int i;
		send_req(FN_DELETE, 5'd3, '0, '0);            // unknown delete
		send_req(FN_ADJUST, 5'd31, '0, '0);           // unknown adjust
		send_req(FN_TICK, 5'd0, '0, '0);              // empty tick
		send_req(FN_ADD, 5'd0, 32'hFFFF_FFFF, '1);
		send_req(FN_ADD, 5'd0, 32'd5, '0);            // duplicate add
		send_req(FN_ADD, 5'd31, 32'd0, '0);
		send_req(FN_ADD, 5'd7, 32'd100, '0);
		send_req(FN_ADD, 5'd8, 32'd100, '0);          // equal expiry goes after
		send_req(FN_ADJUST, 5'd0, 32'd50, '0);        // move earlier
		send_req(FN_ADJUST, 5'd31, 32'd200, '0);      // move later
		send_req(FN_DELETE, 5'd8, '0, '0);
		send_req(FN_TICK, 5'd0, '0, 32'd99);
		send_req(FN_TICK, 5'd0, '0, 32'hFFFF_FFFF);   // drains everything
		// add every id to fill the table (adds past DEPTH see it full), then id 4 again as a duplicate
		for (i = 0; i < NUM_IDS; i++)
			send_req(FN_ADD, i[ID_W-1:0], $urandom_range(0, 3), '0);
		send_req(FN_ADD, 5'd4, '0, '0);
		send_req(FN_TICK, 5'd0, '0, 32'hFFFF_FFFF);
		drain();
	endtask

	// random operations over a narrow window of times so ticks expire things
	task automatic test_random(input int count);
		int i;
		int sel;
		logic [31:0] base;
		for (i = 0; i < count; i++) begin
			sel  = $urandom_range(0, 9);
			base = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
			if (sel < 4)
				send_req(FN_ADD, ID_W'($urandom_range(0, 31)), base, $urandom);
			else if (sel < 6)
				send_req(FN_ADJUST, ID_W'($urandom_range(0, 31)), base, $urandom);
			else if (sel < 7)
				send_req(FN_DELETE, ID_W'($urandom_range(0, 31)), $urandom, $urandom);
			else
				send_req(FN_TICK, ID_W'($urandom_range(0, 31)), $urandom,
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		n_err     = 0;
		n_cyc     = 0;
		quiet     = 1'b0;
		list_len  = 0;
		for (int i = 0; i < NUM_IDS; i++) begin
			active_of[i] = 1'b0;
			expiry_of[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(180);
		quiet = 1'b1;
		test_random(53);
		drain();
		if (n_err == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
